>>> hdl/gcri_pkg.sv
// ----------------------------------------------------------------------------
// gcri_pkg
// Shared types, codes and defaults for the glyph cache with range index.
// ----------------------------------------------------------------------------
package gcri_pkg;

  // Default parameter values.
  localparam int DEF_CACHE_SLOTS     = 16;
  localparam int DEF_RANGE_SLOTS     = 256;
  localparam int DEF_POOL_BYTES      = 32768;
  localparam int DEF_DIR_ENTRY_BYTES = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_BASE    = 2'd2;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_FILL   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_type_e;

  typedef enum logic [3:0] {
    ST_HIT      = 4'd0,
    ST_MISS     = 4'd1,
    ST_NOTFOUND = 4'd2,
    ST_FILLED   = 4'd3,
    ST_TOOLARGE = 4'd4,
    ST_NOTREADY = 4'd5,
    ST_MOVE     = 4'd6,
    ST_DONE     = 4'd7,
    ST_FULL     = 4'd8
  } status_e;

  typedef enum logic [3:0] {
    TS_IDLE,
    TS_LK_CHK,
    TS_LK_SRCH,
    TS_FL_CHECK,
    TS_EV_START,
    TS_EV_SEL,
    TS_EV_CMP,
    TS_EV_DONE,
    TS_FL_ALLOC
  } top_state_e;

  typedef enum logic [1:0] {
    SS_IDLE,
    SS_READ,
    SS_CMP,
    SS_ADDR
  } srch_state_e;

  // One cache entry as stored in the entry memory.
  typedef struct packed {
    logic [20:0] code;
    logic [31:0] age;
    logic [15:0] offset;
    logic [15:0] size;
    logic [63:0] metrics;
  } entry_t;

  // One word of the range table.
  typedef struct packed {
    logic [20:0] first;
    logic [20:0] last;
    logic [31:0] dir_start;
  } range_word_t;

  // Range table write from a load transaction.
  typedef struct packed {
    logic        we;
    logic [7:0]  idx;
    range_word_t word;
  } range_load_t;

  typedef struct packed {
    logic        start;
    logic [20:0] cp;
  } srch_req_t;

  typedef struct packed {
    logic        done;
    logic        found;
    logic [31:0] addr;
  } srch_rsp_t;

  // One result transaction.
  typedef struct packed {
    status_e     status;
    logic [3:0]  slot;
    logic [15:0] pool_offset;
    logic [15:0] byte_count;
    logic [14:0] move_source;
    logic [31:0] dir_addr;
    logic [63:0] metrics;
    logic        last;
  } res_t;

  // A final result with the given status, last set and all other fields zero.
  function automatic res_t mk_res(status_e st);
    res_t r;
    r        = '0;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

endpackage

>>> hdl/gcri_if.sv
// ----------------------------------------------------------------------------
// gcri_if
// Request and result channel interfaces of the glyph cache.
// ----------------------------------------------------------------------------
interface gcri_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [20:0] codepoint;
  logic [7:0]  range_index;
  logic [20:0] range_first;
  logic [20:0] range_last;
  logic [31:0] range_dir_start;
  logic [15:0] fill_length;
  logic [63:0] fill_metrics;

  modport source (
    output valid, req_type, codepoint, range_index, range_first, range_last,
           range_dir_start, fill_length, fill_metrics,
    input  ready
  );
  modport sink (
    input  valid, req_type, codepoint, range_index, range_first, range_last,
           range_dir_start, fill_length, fill_metrics,
    output ready
  );
endinterface

interface gcri_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [3:0]  slot;
  logic [15:0] pool_offset;
  logic [15:0] byte_count;
  logic [14:0] move_source;
  logic [31:0] directory_address;
  logic [63:0] glyph_metrics;
  logic        last;

  modport source (
    output valid, status, slot, pool_offset, byte_count, move_source,
           directory_address, glyph_metrics, last,
    input  ready
  );
  modport sink (
    input  valid, status, slot, pool_offset, byte_count, move_source,
           directory_address, glyph_metrics, last,
    output ready
  );
endinterface

>>> hdl/glyph_cache_with_range_index_top.sv
// ----------------------------------------------------------------------------
// glyph_cache_with_range_index_top
// Fully associative glyph cache over a byte pool with a sorted range index.
// ----------------------------------------------------------------------------
// Requests arrive on req_i and results leave on res_o, both valid/ready
// channels; a transaction moves on a clock edge with valid and ready high.
// Every request gives one or more results, the final one flagged by last.
// The block works on one request at a time and takes a new one only when it
// is idle and its result register is free or being drained.
// Load, clear and not-ready answers are written from the idle state, and a
// fill with pool room and a free slot goes straight to allocation. A lookup
// walks the entry memory one slot per cycle; on a miss the range table is
// binary searched, one table read and one compare per step, and the
// directory address is formed in a last step. An eviction costs one
// entry-memory pass per distinct age rank up to CACHE_SLOTS/4 passes, plus
// one compaction pass that emits a move result per relocated bitmap; every
// pass uses the single entry-memory read port. Reset empties the cache and
// clears the control and configuration registers; the range table holds no
// reset value and must be loaded before it is searched. When the receiver
// stalls, the pending result holds and no new result replaces it.
// ----------------------------------------------------------------------------
module glyph_cache_with_range_index_top import gcri_pkg::*; #(
  parameter int CACHE_SLOTS     = DEF_CACHE_SLOTS,
  parameter int RANGE_SLOTS     = DEF_RANGE_SLOTS,
  parameter int POOL_BYTES      = DEF_POOL_BYTES,
  parameter int DIR_ENTRY_BYTES = DEF_DIR_ENTRY_BYTES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  gcri_req_if.sink              req_i,
  gcri_res_if.source            res_o
);

  localparam int SW    = $clog2(CACHE_SLOTS);
  localparam int CNTW  = $clog2(CACHE_SLOTS + 1);
  localparam int EVICT = CACHE_SLOTS / 4;

  // Configuration registers.
  logic        enabled_q;
  logic [8:0]  range_count_q;
  logic [31:0] dir_base_q;

  // Entry memory.
  entry_t         ent_mem [CACHE_SLOTS];
  entry_t         ent_rd_q, ent_wdata;
  logic           ent_re, ent_we;
  logic [SW-1:0]  ent_raddr, ent_waddr;

  // Control and working registers.
  top_state_e        state_q, state_d;
  logic [CACHE_SLOTS-1:0] valid_q, valid_d;
  logic [15:0]       pool_q, pool_d;
  logic [31:0]       acc_q, acc_d;
  logic              out_vld_q, out_vld_d;
  res_t              res_q, res_d;
  logic [SW-1:0]     i_q, i_d;
  logic [20:0]       cp_q, cp_d;
  logic [15:0]       len_q, len_d;
  logic [63:0]       met_q, met_d;
  logic [31:0]       thr_q, thr_d, bound_q, bound_d, min_q, min_d;
  logic              bvld_q, bvld_d, evslot_q, evslot_d;
  logic [CNTW-1:0]   mcnt_q, mcnt_d, taken_q, taken_d;
  logic [15:0]       np_q, np_d;

  // Helpers.
  logic              out_free, ready, i_last, free_any, over, too_big, cand, adv;
  logic [SW-1:0]     free_idx;
  logic [CNTW-1:0]   vcnt, kk, nmcnt, taken_n;
  logic [31:0]       nmin, acc_inc;
  logic [15:0]       np_n;
  srch_req_t         srch_req;
  srch_rsp_t         srch_rsp;
  range_load_t       load;

  gcri_search #(
    .RANGE_SLOTS     (RANGE_SLOTS),
    .DIR_ENTRY_BYTES (DIR_ENTRY_BYTES)
  ) u_search (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .req_i         (srch_req),
    .range_count_i (range_count_q),
    .dir_base_i    (dir_base_q),
    .rsp_o         (srch_rsp)
  );

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q     <= 1'b0;
      range_count_q <= '0;
      dir_base_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENABLED:     enabled_q     <= cfg_wdata_i[0];
        CFG_RANGE_COUNT: range_count_q <= cfg_wdata_i[8:0];
        CFG_DIR_BASE:    dir_base_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Entry memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rd_q <= ent_mem[ent_raddr];
    end
  end

  // Occupancy summary: valid count, eviction quota and lowest free slot.
  always_comb begin
    vcnt     = '0;
    free_idx = '0;
    for (int s = 0; s < CACHE_SLOTS; s++) begin
      vcnt = vcnt + CNTW'(valid_q[s]);
    end
    for (int s = CACHE_SLOTS - 1; s >= 0; s--) begin
      if (!valid_q[s]) begin
        free_idx = SW'(s);
      end
    end
  end

  assign free_any = ~&valid_q;
  assign kk       = (vcnt < CNTW'(EVICT)) ? vcnt : CNTW'(EVICT);
  assign out_free = !out_vld_q || res_o.ready;
  assign ready    = (state_q == TS_IDLE) && out_free;
  assign i_last   = (i_q == SW'(CACHE_SLOTS - 1));
  assign over     = (len_q != '0) &&
                    ((17'(pool_q) + 17'(len_q)) > 17'(POOL_BYTES));
  assign too_big  = 17'(len_q) > 17'(POOL_BYTES);
  assign acc_inc  = acc_q + 32'd1;

  // Range table load from the request payload.
  assign load.we             = (state_q == TS_IDLE) && req_i.valid && ready &&
                               (req_type_e'(req_i.req_type) == REQ_LOAD);
  assign load.idx            = req_i.range_index;
  assign load.word.first     = req_i.range_first;
  assign load.word.last      = req_i.range_last;
  assign load.word.dir_start = req_i.range_dir_start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= TS_IDLE;
      valid_q   <= '0;
      pool_q    <= '0;
      acc_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      pool_q    <= pool_d;
      acc_q     <= acc_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    i_q      <= i_d;
    cp_q     <= cp_d;
    len_q    <= len_d;
    met_q    <= met_d;
    thr_q    <= thr_d;
    bound_q  <= bound_d;
    min_q    <= min_d;
    bvld_q   <= bvld_d;
    evslot_q <= evslot_d;
    mcnt_q   <= mcnt_d;
    taken_q  <= taken_d;
    np_q     <= np_d;
  end

  // Main sequencer: next state, memory accesses and results.
  always_comb begin
    state_d   = state_q;
    valid_d   = valid_q;
    pool_d    = pool_q;
    acc_d     = acc_q;
    out_vld_d = out_vld_q && !res_o.ready;
    res_d     = res_q;
    i_d       = i_q;
    cp_d      = cp_q;
    len_d     = len_q;
    met_d     = met_q;
    thr_d     = thr_q;
    bound_d   = bound_q;
    min_d     = min_q;
    bvld_d    = bvld_q;
    evslot_d  = evslot_q;
    mcnt_d    = mcnt_q;
    taken_d   = taken_q;
    np_d      = np_q;
    ent_re    = 1'b0;
    ent_raddr = '0;
    ent_we    = 1'b0;
    ent_waddr = i_q;
    ent_wdata = ent_rd_q;
    srch_req  = '{start: 1'b0, cp: cp_q};
    cand      = 1'b0;
    nmin      = min_q;
    nmcnt     = mcnt_q;
    taken_n   = taken_q;
    np_n      = np_q;
    adv       = 1'b0;

    unique case (state_q)
      TS_IDLE: begin
        if (req_i.valid && ready) begin
          cp_d  = req_i.codepoint;
          len_d = req_i.fill_length;
          met_d = req_i.fill_metrics;
          unique case (req_type_e'(req_i.req_type))
            REQ_LOAD: begin
              res_d     = mk_res(ST_DONE);
              out_vld_d = 1'b1;
            end
            REQ_CLEAR: begin
              valid_d   = '0;
              pool_d    = '0;
              acc_d     = '0;
              res_d     = mk_res(ST_DONE);
              out_vld_d = 1'b1;
            end
            REQ_LOOKUP, REQ_FILL: begin
              if (!enabled_q) begin
                res_d     = mk_res(ST_NOTREADY);
                out_vld_d = 1'b1;
              end else if (req_type_e'(req_i.req_type) == REQ_LOOKUP) begin
                i_d     = '0;
                ent_re  = 1'b1;
                state_d = TS_LK_CHK;
              end else begin
                state_d = TS_FL_CHECK;
              end
            end
            default: ;
          endcase
        end
      end

      // Associative match, one slot per cycle, lowest slot first.
      TS_LK_CHK: begin
        if (valid_q[i_q] && (ent_rd_q.code == cp_q)) begin
          if (out_free) begin
            acc_d               = acc_inc;
            ent_we              = 1'b1;
            ent_wdata.age       = acc_inc;
            res_d               = mk_res(ST_HIT);
            res_d.slot          = 4'(i_q);
            res_d.pool_offset   = ent_rd_q.offset;
            res_d.byte_count    = ent_rd_q.size;
            res_d.metrics       = ent_rd_q.metrics;
            out_vld_d           = 1'b1;
            state_d             = TS_IDLE;
          end
        end else if (i_last) begin
          srch_req.start = 1'b1;
          state_d        = TS_LK_SRCH;
        end else begin
          i_d       = i_q + SW'(1);
          ent_re    = 1'b1;
          ent_raddr = i_q + SW'(1);
        end
      end

      // Wait for the range search; the result register is empty here.
      TS_LK_SRCH: begin
        if (srch_rsp.done) begin
          if (srch_rsp.found) begin
            res_d          = mk_res(ST_MISS);
            res_d.dir_addr = srch_rsp.addr;
          end else begin
            res_d = mk_res(ST_NOTFOUND);
          end
          out_vld_d = 1'b1;
          state_d   = TS_IDLE;
        end
      end

      // Fill: make pool room first, then find a slot.
      TS_FL_CHECK: begin
        if (over) begin
          evslot_d = 1'b0;
          state_d  = TS_EV_START;
        end else if (free_any) begin
          state_d = TS_FL_ALLOC;
        end else begin
          evslot_d = 1'b1;
          state_d  = TS_EV_START;
        end
      end

      TS_EV_START: begin
        if (vcnt == '0) begin
          state_d = TS_EV_DONE;
        end else begin
          bvld_d  = 1'b0;
          taken_d = '0;
          mcnt_d  = '0;
          i_d     = '0;
          ent_re  = 1'b1;
          state_d = TS_EV_SEL;
        end
      end

      // Threshold search: each pass finds the next distinct age and its
      // multiplicity until the eviction quota is covered.
      TS_EV_SEL: begin
        cand = valid_q[i_q] && (!bvld_q || (ent_rd_q.age > bound_q));
        if (cand) begin
          if ((mcnt_q == '0) || (ent_rd_q.age < min_q)) begin
            nmin  = ent_rd_q.age;
            nmcnt = CNTW'(1);
          end else if (ent_rd_q.age == min_q) begin
            nmcnt = mcnt_q + CNTW'(1);
          end
        end
        min_d  = nmin;
        mcnt_d = nmcnt;
        ent_re = 1'b1;
        if (i_last) begin
          taken_n = taken_q + nmcnt;
          i_d     = '0;
          if (taken_n >= kk) begin
            thr_d   = nmin;
            np_d    = '0;
            state_d = TS_EV_CMP;
          end else begin
            bound_d = nmin;
            bvld_d  = 1'b1;
            taken_d = taken_n;
            mcnt_d  = '0;
          end
        end else begin
          i_d       = i_q + SW'(1);
          ent_raddr = i_q + SW'(1);
        end
      end

      // Evict and compact in one ordered pass over the slots.
      TS_EV_CMP: begin
        if (valid_q[i_q] && (ent_rd_q.age <= thr_q)) begin
          valid_d[i_q] = 1'b0;
          adv          = 1'b1;
        end else if (valid_q[i_q] && (ent_rd_q.size != '0)) begin
          if (ent_rd_q.offset != np_q) begin
            if (out_free) begin
              ent_we            = 1'b1;
              ent_wdata.offset  = np_q;
              res_d             = mk_res(ST_MOVE);
              res_d.last        = 1'b0;
              res_d.slot        = 4'(i_q);
              res_d.pool_offset = np_q;
              res_d.byte_count  = ent_rd_q.size;
              res_d.move_source = ent_rd_q.offset[14:0];
              out_vld_d         = 1'b1;
              np_n              = np_q + ent_rd_q.size;
              adv               = 1'b1;
            end
          end else begin
            np_n = np_q + ent_rd_q.size;
            adv  = 1'b1;
          end
        end else begin
          adv = 1'b1;
        end
        if (adv) begin
          np_d = np_n;
          if (i_last) begin
            pool_d  = np_n;
            state_d = TS_EV_DONE;
          end else begin
            i_d       = i_q + SW'(1);
            ent_re    = 1'b1;
            ent_raddr = i_q + SW'(1);
          end
        end
      end

      TS_EV_DONE: begin
        if (evslot_q) begin
          if (free_any) begin
            state_d = TS_FL_ALLOC;
          end else if (out_free) begin
            res_d     = mk_res(ST_FULL);
            out_vld_d = 1'b1;
            state_d   = TS_IDLE;
          end
        end else if (over) begin
          // Still no room: drop everything.
          if (!too_big) begin
            valid_d = '0;
            pool_d  = '0;
            acc_d   = '0;
            state_d = TS_FL_ALLOC;
          end else if (out_free) begin
            valid_d   = '0;
            pool_d    = '0;
            acc_d     = '0;
            res_d     = mk_res(ST_TOOLARGE);
            out_vld_d = 1'b1;
            state_d   = TS_IDLE;
          end
        end else if (free_any) begin
          state_d = TS_FL_ALLOC;
        end else begin
          evslot_d = 1'b1;
          state_d  = TS_EV_START;
        end
      end

      TS_FL_ALLOC: begin
        if (out_free) begin
          acc_d             = acc_inc;
          ent_we            = 1'b1;
          ent_waddr         = free_idx;
          ent_wdata         = '{code: cp_q, age: acc_inc, offset: pool_q,
                                size: len_q, metrics: met_q};
          valid_d[free_idx] = 1'b1;
          res_d             = mk_res(ST_FILLED);
          res_d.slot        = 4'(free_idx);
          res_d.pool_offset = pool_q;
          res_d.byte_count  = len_q;
          res_d.metrics     = met_q;
          out_vld_d         = 1'b1;
          pool_d            = pool_q + len_q;
          state_d           = TS_IDLE;
        end
      end

      default: state_d = TS_IDLE;
    endcase
  end

  // Channel outputs.
  assign req_i.ready             = ready;
  assign res_o.valid             = out_vld_q;
  assign res_o.status            = res_q.status;
  assign res_o.slot              = res_q.slot;
  assign res_o.pool_offset       = res_q.pool_offset;
  assign res_o.byte_count        = res_q.byte_count;
  assign res_o.move_source       = res_q.move_source;
  assign res_o.directory_address = res_q.dir_addr;
  assign res_o.glyph_metrics     = res_q.metrics;
  assign res_o.last              = res_q.last;

endmodule

>>> hdl/gcri_search.sv
// ----------------------------------------------------------------------------
// gcri_search
// Range table memory and binary search that yields a directory byte address.
// ----------------------------------------------------------------------------
module gcri_search import gcri_pkg::*; #(
  parameter int RANGE_SLOTS     = DEF_RANGE_SLOTS,
  parameter int DIR_ENTRY_BYTES = DEF_DIR_ENTRY_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  range_load_t load_i,
  input  srch_req_t   req_i,
  input  logic [8:0]  range_count_i,
  input  logic [31:0] dir_base_i,
  output srch_rsp_t   rsp_o
);

  localparam int RIW = (RANGE_SLOTS > 1) ? $clog2(RANGE_SLOTS) : 1;
  localparam int CW  = $clog2(RANGE_SLOTS + 1);

  range_word_t tbl_mem [RANGE_SLOTS];
  range_word_t rd_q;
  logic           rd_en;
  logic [RIW-1:0] rd_addr;

  srch_state_e state_q, state_d;
  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, mid;
  logic [CW-1:0] cnt;
  logic [20:0]   cp_q, cp_d;
  logic [31:0]   idx_q, idx_d;
  srch_rsp_t     rsp_q, rsp_d;

  // Table memory: one write port for loads, one registered read port.
  always_ff @(posedge clk_i) begin
    if (load_i.we && (32'(load_i.idx) < 32'(RANGE_SLOTS))) begin
      tbl_mem[RIW'(load_i.idx)] <= load_i.word;
    end
    if (rd_en) begin
      rd_q <= tbl_mem[rd_addr];
    end
  end

  // Number of ranges in use is capped at the table depth.
  always_comb begin
    if (32'(range_count_i) < 32'(RANGE_SLOTS)) begin
      cnt = CW'(range_count_i);
    end else begin
      cnt = CW'(RANGE_SLOTS);
    end
  end

  // Midpoint of the half-open interval [lo, hi).
  assign mid = lo_q + ((hi_q - lo_q - CW'(1)) >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SS_IDLE;
      rsp_q   <= '0;
    end else begin
      state_q <= state_d;
      rsp_q   <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    cp_q  <= cp_d;
    idx_q <= idx_d;
  end

  // Search sequencer: one table read and one compare per step.
  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    cp_d    = cp_q;
    idx_d   = idx_q;
    rsp_d   = rsp_q;
    rsp_d.done = 1'b0;
    rd_en   = 1'b0;
    rd_addr = RIW'(mid);
    unique case (state_q)
      SS_IDLE: begin
        if (req_i.start) begin
          lo_d    = '0;
          hi_d    = cnt;
          cp_d    = req_i.cp;
          state_d = SS_READ;
        end
      end
      SS_READ: begin
        if (lo_q < hi_q) begin
          rd_en   = 1'b1;
          mid_d   = mid;
          state_d = SS_CMP;
        end else begin
          rsp_d   = '{done: 1'b1, found: 1'b0, addr: '0};
          state_d = SS_IDLE;
        end
      end
      SS_CMP: begin
        if (cp_q < rd_q.first) begin
          hi_d    = mid_q;
          state_d = SS_READ;
        end else if (cp_q > rd_q.last) begin
          lo_d    = mid_q + CW'(1);
          state_d = SS_READ;
        end else begin
          idx_d   = rd_q.dir_start + (32'(cp_q) - 32'(rd_q.first));
          state_d = SS_ADDR;
        end
      end
      SS_ADDR: begin
        rsp_d = '{done: 1'b1, found: 1'b1,
                  addr: dir_base_i + idx_q * 32'(DIR_ENTRY_BYTES)};
        state_d = SS_IDLE;
      end
      default: state_d = SS_IDLE;
    endcase
  end

  assign rsp_o = rsp_q;

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the glyph cache with range index. A directed
// stimulus table covers the register defaults, the table extremes and the
// eviction corners. It is followed by random lookups, fills, loads and clears
// over several register settings. Every result transaction is checked field
// by field against an in-bench model of the cache, or, for typed directed entries, against their stated status.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import gcri_pkg::*;

  localparam int SLOTS   = DEF_CACHE_SLOTS;
  localparam int RANGES  = DEF_RANGE_SLOTS;
  localparam int POOL    = DEF_POOL_BYTES;
  localparam int DIRSZ   = DEF_DIR_ENTRY_BYTES;
  localparam int EVICTN  = SLOTS / 4;
  localparam int LIMIT   = 1000000;

  typedef struct {
    req_type_e   kind;
    logic [20:0] cp;
    logic [7:0]  ri;
    logic [20:0] first;
    logic [20:0] final_cp;
    logic [31:0] dir;
    logic [15:0] len;
    logic [63:0] met;
    bit          typed;
    status_e     want;
  } glyph_req_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  gcri_req_if req_if ();
  gcri_res_if res_if ();

  glyph_cache_with_range_index_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  // Model state of the cache.
  logic        en_reg;
  logic [8:0]  rcount_reg;
  logic [31:0] base_reg;
  logic        slot_valid [SLOTS];
  logic [20:0] slot_code  [SLOTS];
  logic [31:0] slot_age   [SLOTS];
  int unsigned slot_off   [SLOTS];
  int unsigned slot_size  [SLOTS];
  logic [63:0] slot_met   [SLOTS];
  int unsigned pool_fill;
  logic [31:0] age_clock;
  logic [20:0] rng_first [RANGES];
  logic [20:0] rng_final [RANGES];
  logic [31:0] rng_dir   [RANGES];

  res_t        step_out [$];
  res_t        expected_results [$];
  int          errors;
  int          mismatches;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;
  glyph_req_t  directed [$];

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle counter, quiet window and timeout.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    calm <= (cycle_count >= 1000 && cycle_count < 2500);
    if (cycle_count >= LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void emit(status_e st, int sl, int unsigned off, int unsigned cnt,
                               int unsigned src, logic [31:0] dir, logic [63:0] met);
    res_t r;
    r             = '0;
    r.status      = st;
    r.slot        = 4'(sl);
    r.pool_offset = 16'(off);
    r.byte_count  = 16'(cnt);
    r.move_source = 15'(src);
    r.dir_addr    = dir;
    r.metrics     = met;
    step_out.push_back(r);
  endfunction

  function automatic void wipe_entries();
    for (int i = 0; i < SLOTS; i++) slot_valid[i] = 1'b0;
    pool_fill = 0;
    age_clock = '0;
  endfunction

  // Drop every entry aged at or below the quarter-th oldest, then pack the pool.
  function automatic void evict_and_pack();
    logic [31:0] ages [SLOTS];
    int          cnt;
    int          j;
    int          k;
    logic [31:0] thr;
    int unsigned np;
    cnt = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_valid[i]) begin
        j = cnt;
        while (j > 0 && ages[j-1] > slot_age[i]) begin
          ages[j] = ages[j-1];
          j--;
        end
        ages[j] = slot_age[i];
        cnt++;
      end
    end
    if (cnt == 0) return;
    k   = (EVICTN < cnt) ? EVICTN : cnt;
    thr = ages[k-1];
    for (int i = 0; i < SLOTS; i++)
      if (slot_valid[i] && slot_age[i] <= thr) slot_valid[i] = 1'b0;
    np = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!slot_valid[i] || slot_size[i] == 0) continue;
      if (slot_off[i] != np) begin
        emit(ST_MOVE, i, np, slot_size[i], slot_off[i], '0, '0);
        slot_off[i] = np;
      end
      np += slot_size[i];
    end
    pool_fill = np;
  endfunction

  function automatic int first_free();
    for (int i = 0; i < SLOTS; i++)
      if (!slot_valid[i]) return i;
    return -1;
  endfunction

  function automatic void lookup_glyph(logic [20:0] cp);
    int          lo;
    int          hi;
    int          mid;
    int unsigned cnt;
    logic [31:0] idx;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_valid[i] && slot_code[i] == cp) begin
        age_clock   = age_clock + 1;
        slot_age[i] = age_clock;
        emit(ST_HIT, i, slot_off[i], slot_size[i], 0, '0, slot_met[i]);
        return;
      end
    end
    cnt = (rcount_reg < RANGES) ? rcount_reg : RANGES;
    lo  = 0;
    hi  = int'(cnt) - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (cp < rng_first[mid]) hi = mid - 1;
      else if (cp > rng_final[mid]) lo = mid + 1;
      else begin
        idx = rng_dir[mid] + (32'(cp) - 32'(rng_first[mid]));
        emit(ST_MISS, 0, 0, 0, 0, base_reg + idx * DIRSZ, '0);
        return;
      end
    end
    emit(ST_NOTFOUND, 0, 0, 0, 0, '0, '0);
  endfunction

  function automatic void fill_glyph(logic [20:0] cp, int unsigned len, logic [63:0] met);
    int s;
    if (len > 0) begin
      while (pool_fill + len > POOL) begin
        evict_and_pack();
        if (pool_fill + len > POOL) begin
          wipe_entries();
          if (len > POOL) begin
            emit(ST_TOOLARGE, 0, 0, 0, 0, '0, '0);
            return;
          end
        end
      end
    end
    s = first_free();
    if (s < 0) begin
      evict_and_pack();
      s = first_free();
      if (s < 0) begin
        emit(ST_FULL, 0, 0, 0, 0, '0, '0);
        return;
      end
    end
    age_clock     = age_clock + 1;
    slot_code[s]  = cp;
    slot_age[s]   = age_clock;
    slot_off[s]   = pool_fill;
    slot_size[s]  = len;
    slot_met[s]   = met;
    slot_valid[s] = 1'b1;
    emit(ST_FILLED, s, pool_fill, len, 0, '0, met);
    pool_fill += len;
  endfunction

  // Work out the results of one accepted request and queue them.
  function automatic void predict_glyph_results(glyph_req_t r);
    step_out.delete();
    case (r.kind)
      REQ_LOAD: begin
        rng_first[r.ri] = r.first;
        rng_final[r.ri] = r.final_cp;
        rng_dir[r.ri]   = r.dir;
        emit(ST_DONE, 0, 0, 0, 0, '0, '0);
      end
      REQ_CLEAR: begin
        wipe_entries();
        emit(ST_DONE, 0, 0, 0, 0, '0, '0);
      end
      REQ_LOOKUP: begin
        if (!en_reg) emit(ST_NOTREADY, 0, 0, 0, 0, '0, '0);
        else lookup_glyph(r.cp);
      end
      default: begin
        if (!en_reg) emit(ST_NOTREADY, 0, 0, 0, 0, '0, '0);
        else fill_glyph(r.cp, r.len, r.met);
      end
    endcase
    if (r.typed) begin
      step_out.delete();
      step_out.push_back(mk_res(r.want));
    end
    step_out[step_out.size()-1].last = 1'b1;
    foreach (step_out[i]) expected_results.push_back(step_out[i]);
  endfunction

  function automatic glyph_req_t mk(req_type_e kind, logic [20:0] cp, logic [7:0] ri,
                                    logic [20:0] first, logic [20:0] fin, logic [31:0] dir,
                                    logic [15:0] len, logic [63:0] met, bit typed,
                                    status_e want);
    glyph_req_t r;
    r.kind = kind; r.cp = cp; r.ri = ri; r.first = first; r.final_cp = fin;
    r.dir = dir; r.len = len; r.met = met; r.typed = typed; r.want = want;
    return r;
  endfunction

  // Offer one request transaction, with random gaps, and predict on acceptance.
  task automatic send_req(glyph_req_t r);
    while (!calm && $urandom_range(0, 99) < 36) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid           <= 1'b1;
    req_if.req_type        <= r.kind;
    req_if.codepoint       <= r.cp;
    req_if.range_index     <= r.ri;
    req_if.range_first     <= r.first;
    req_if.range_last      <= r.final_cp;
    req_if.range_dir_start <= r.dir;
    req_if.fill_length     <= r.len;
    req_if.fill_metrics    <= r.met;
    do @(posedge clk_i); while (!req_if.ready);
    predict_glyph_results(r);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register write while the block is idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_ENABLED) en_reg = data[0];
    else if (idx == CFG_RANGE_COUNT) rcount_reg = data[8:0];
    else if (idx == CFG_DIR_BASE) base_reg = data;
  endtask

  task automatic set_all(logic en, logic [8:0] rc, logic [31:0] base);
    write_reg(CFG_ENABLED, {31'd0, en});
    write_reg(CFG_RANGE_COUNT, {23'd0, rc});
    write_reg(CFG_DIR_BASE, base);
  endtask

  function automatic logic [20:0] pick_code();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 70) return 21'($urandom_range(0, 47) * 7);
    if (p < 90) return 21'($urandom_range(0, 4200));
    return 21'($urandom_range(0, 1114111));
  endfunction

  function automatic logic [15:0] pick_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 10) return 16'd0;
    if (p < 90) return 16'($urandom_range(1, 6000));
    if (p < 98) return 16'($urandom_range(6001, 32768));
    return 16'($urandom_range(32769, 65535));
  endfunction

  function automatic glyph_req_t random_req();
    int unsigned p;
    glyph_req_t  r;
    p = $urandom_range(0, 99);
    r = mk(REQ_LOOKUP, pick_code(), 8'($urandom), 21'($urandom_range(0, 1114111)),
           21'($urandom_range(0, 1114111)), $urandom, pick_len(), {$urandom, $urandom},
           1'b0, ST_HIT);
    if (p < 6) r.kind = REQ_LOAD;
    else if (p < 9) r.kind = REQ_CLEAR;
    else if (p < 58) r.kind = REQ_LOOKUP;
    else r.kind = REQ_FILL;
    return r;
  endfunction

  // Result side: random stalls and the field-by-field check.
  always @(posedge clk_i) begin : result_check
    res_t want;
    res_t got;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        got             = '0;
        got.status      = status_e'(res_if.status);
        got.slot        = res_if.slot;
        got.pool_offset = res_if.pool_offset;
        got.byte_count  = res_if.byte_count;
        got.move_source = res_if.move_source;
        got.dir_addr    = res_if.directory_address;
        got.metrics     = res_if.glyph_metrics;
        got.last        = res_if.last;
        if (expected_results.size() == 0) begin
          errors++;
          if (mismatches < 10)
            $display("unexpected result transaction: status %0d slot %0d", got.status,
                     got.slot);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            errors++;
            if (mismatches < 10) begin
              $display("mismatch exp st=%0d sl=%0d off=%0d cnt=%0d src=%0d dir=%h met=%h l=%b",
                       want.status, want.slot, want.pool_offset, want.byte_count,
                       want.move_source, want.dir_addr, want.metrics, want.last);
              $display("         got st=%0d sl=%0d off=%0d cnt=%0d src=%0d dir=%h met=%h l=%b",
                       got.status, got.slot, got.pool_offset, got.byte_count,
                       got.move_source, got.dir_addr, got.metrics, got.last);
            end
            mismatches++;
          end
        end
      end
    end
    res_if.ready <= calm || ($urandom_range(0, 99) >= 36);
  end

  // Stimulus.
  initial begin
    glyph_req_t r;
    errors      = 0;
    mismatches  = 0;
    en_reg      = 1'b0;
    rcount_reg  = '0;
    base_reg    = '0;
    wipe_entries();
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_ENABLED;
    cfg_wdata_i  = '0;
    req_if.valid = 1'b0;
    req_if.req_type        = REQ_LOAD;
    req_if.codepoint       = '0;
    req_if.range_index     = '0;
    req_if.range_first     = '0;
    req_if.range_last      = '0;
    req_if.range_dir_start = '0;
    req_if.fill_length     = '0;
    req_if.fill_metrics    = '0;

    // Reset defaults: disabled, then a small sorted table with a wrapping range.
    directed.push_back(mk(REQ_LOOKUP, 21'd0, 0, 0, 0, 0, 0, 0, 1, ST_NOTREADY));
    directed.push_back(mk(REQ_FILL, 21'h10FFFF, 0, 0, 0, 0, 16'd5, '1, 1, ST_NOTREADY));
    directed.push_back(mk(REQ_LOAD, 0, 8'd0, 21'h20, 21'h7E, 32'd0, 0, 0, 1, ST_DONE));
    directed.push_back(mk(REQ_LOAD, 0, 8'd1, 21'hA0, 21'h17F, 32'd95, 0, 0, 1, ST_DONE));
    directed.push_back(mk(REQ_LOAD, 0, 8'd2, 21'h4E00, 21'h9FFF, 32'd2000, 0, 0, 1,
                          ST_DONE));
    directed.push_back(mk(REQ_LOAD, 0, 8'd3, 21'h10FF00, 21'h10FFFF, 32'hFFFF_FFF0, 0, 0, 1,
                          ST_DONE));
    directed.push_back(mk(REQ_LOAD, 0, 8'd255, 21'h1FFFFF, 21'h1FFFFF, '1, 0, 0, 1,
                          ST_DONE));
    directed.push_back(mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1, ST_DONE));
    // Enabled, four ranges: misses, gaps, hits, duplicates, zero length, oversize.
    directed.push_back(mk(REQ_LOOKUP, 21'h41, 0, 0, 0, 0, 0, 0, 0, ST_HIT));
    directed.push_back(mk(REQ_LOOKUP, 21'h1F, 0, 0, 0, 0, 0, 0, 1, ST_NOTFOUND));
    directed.push_back(mk(REQ_LOOKUP, 21'h10FFFF, 0, 0, 0, 0, 0, 0, 0, ST_HIT));
    directed.push_back(mk(REQ_LOOKUP, 21'h180, 0, 0, 0, 0, 0, 0, 1, ST_NOTFOUND));
    directed.push_back(mk(REQ_FILL, 21'h41, 0, 0, 0, 0, 16'd100, '1, 0, ST_HIT));
    directed.push_back(mk(REQ_LOOKUP, 21'h41, 0, 0, 0, 0, 0, 0, 0, ST_HIT));
    directed.push_back(mk(REQ_FILL, 21'h41, 0, 0, 0, 0, 16'd0, '0, 0, ST_HIT));
    directed.push_back(mk(REQ_LOOKUP, 21'h41, 0, 0, 0, 0, 0, 0, 0, ST_HIT));
    directed.push_back(mk(REQ_FILL, 21'h42, 0, 0, 0, 0, 16'hFFFF, '1, 0, ST_HIT));
    directed.push_back(mk(REQ_FILL, 21'h43, 0, 0, 0, 0, 16'd32768, 64'h5A, 0, ST_HIT));
    directed.push_back(mk(REQ_FILL, 21'h44, 0, 0, 0, 0, 16'd1, 64'hA5, 0, ST_HIT));
    directed.push_back(mk(REQ_FILL, 21'h10FFFF, 0, 0, 0, 0, 16'd0, '0, 0, ST_HIT));
    directed.push_back(mk(REQ_LOOKUP, 21'h10FFFF, 0, 0, 0, 0, 0, 0, 0, ST_HIT));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (i == 8) set_all(1'b1, 9'd4, 32'hFFFF_FF00);
      send_req(directed[i]);
    end

    // Full sorted table so that every range count is safe to search.
    for (int i = 0; i < RANGES; i++)
      send_req(mk(REQ_LOAD, 0, 8'(i), 21'(i * 16), 21'(i * 16 + 9), $urandom, 0, 0, 0,
                  ST_HIT));

    // Random phases over several register settings.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_all(1'b1, 9'd256, $urandom);
        1: set_all(1'b1, 9'd511, 32'hFFFF_FFFF);
        2: set_all(1'b0, 9'd1, $urandom);
        3: set_all(1'b1, 9'd1, 32'h0000_0010);
        4: set_all(1'b1, 9'd0, 32'h0000_0000);
        default: set_all(1'b1, 9'd100, $urandom);
      endcase
      for (int n = 0; n < ((ph == 2) ? 4 : 14); n++) begin
        r = random_req();
        send_req(r);
      end
    end

    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
